>>> rtl/core/pixel_gradient_magnitude_orientation_core_assert.svh
// Assertion macros for the gradient magnitude and orientation core
`ifndef PIXEL_GRADIENT_MAGNITUDE_ORIENTATION_CORE_ASSERT_SVH
`define PIXEL_GRADIENT_MAGNITUDE_ORIENTATION_CORE_ASSERT_SVH

// same-cycle implication
`define PGMO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PGMO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pgmo_pkg.sv
// Shared types, constants and control structs of the gradient core
package pgmo_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int PIX_W      = 8;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 12;
   localparam int CFG_W_W    = 11;
   localparam int CFG_H_W    = 12;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int MAG_W      = 13;
   localparam int ORI_W      = 16;
   localparam int FRAC       = 44;
   localparam int TERM_W     = 44;
   localparam int PROD_W     = 54;
   localparam int ANG_W      = 46;
   localparam int ARG_W      = 10;
   localparam int N_W        = 8;
   localparam int DIV_W      = 64;
   localparam int DIV_CNT_W  = 6;
   localparam int SQ_W       = 26;
   localparam int K_W        = 14;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 12'd4095;
   localparam logic [CFG_W_W-1:0] WIDTH_MIN    = 11'd3;
   localparam logic [CFG_W_W-1:0] WIDTH_MAX    = 11'd1024;
   localparam logic [CFG_H_W-1:0] HEIGHT_MIN   = 12'd3;
   localparam logic [N_W-1:0]     N_MAX        = 8'd200;

   localparam logic [ORI_W-1:0] ORI_HALF    = 16'd32768;
   localparam logic [ORI_W-1:0] ORI_QUARTER = 16'd16384;
   localparam logic [ORI_W-1:0] ORI_EIGHTH  = 16'd8192;

   localparam logic [ARG_W-1:0] PI_P     = 10'd1;
   localparam logic [ARG_W-1:0] PI_Q_A   = 10'd5;
   localparam logic [ARG_W-1:0] PI_Q_B   = 10'd239;

   typedef logic [DIV_W-1:0]  div_word_type;
   typedef logic [TERM_W-1:0] term_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [ANG_W-1:0]  ang_type;
   typedef logic [ORI_W-1:0]  ori_type;

   typedef enum logic [4:0] {
      ST_PI_A, ST_PI_B, ST_TERM0, ST_CHECK, ST_MUL, ST_SCALE, ST_DIVW,
      ST_SER_END, ST_KDIV, ST_IDLE, ST_READ_A, ST_READ_B, ST_READ_C,
      ST_DECIDE, ST_RES_PREP, ST_EMIT, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {DIV_TERM0, DIV_ADD, DIV_SCALE, DIV_K} div_op_type;
   typedef enum logic [1:0] {JOB_PI5, JOB_PI239, JOB_OCT} job_type;
   typedef enum logic [1:0] {ARG_NONE, ARG_PI5, ARG_PI239} argsel_type;

   typedef struct packed {
      logic       accept;
      argsel_type arg;
      logic       div_start;
      div_op_type div_op;
      logic       mul;
      logic       n_inc;
      logic       ser_end;
      job_type    job;
      logic       rd_b;
      logic       cap_a;
      logic       cap_b;
      logic       setup;
      logic       second;
      logic       load_out;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic has_first;
      logic has_second;
      logic special;
      logic term_zero;
      logic n_max;
      logic div_done;
      logic div_busy;
      logic sqrt_done;
      logic out_free;
   } sts_type;

endpackage

>>> rtl/core/pgmo_if.sv
// Pixel request and gradient response channel interfaces
interface pgmo_req_if;
   logic                        valid;
   logic                        ready;
   logic [pgmo_pkg::PIX_W-1:0]  pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface pgmo_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pgmo_pkg::MAG_W-1:0]  magnitude;
   logic [pgmo_pkg::ORI_W-1:0]  orientation;
   logic [pgmo_pkg::COL_W-1:0]  column;
   logic [pgmo_pkg::ROW_W-1:0]  row;
   logic                        last_in_run;
   modport source (output valid, output magnitude, output orientation, output column,
                   output row, output last_in_run, input ready);
   modport sink (input valid, input magnitude, input orientation, input column,
                 input row, input last_in_run, output ready);
endinterface

>>> rtl/core/pgmo_ram.sv
// Generic single-write, single-read RAM with registered read data
module pgmo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> rtl/core/pgmo_div.sv
// Restoring divider, one quotient bit per cycle
module pgmo_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pgmo_pkg::div_word_type dividend,
   input  pgmo_pkg::div_word_type divisor,
   output logic                   busy,
   output logic                   done,
   output pgmo_pkg::div_word_type quotient
);
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [pgmo_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   pgmo_pkg::div_word_type           rem_ff, rem_in;
   pgmo_pkg::div_word_type           quo_ff, quo_in;
   pgmo_pkg::div_word_type           div_ff, div_in;
   logic [pgmo_pkg::DIV_W:0]         trial, diff;
   logic                             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[pgmo_pkg::DIV_W-1]};
      diff    = trial - {1'b0, div_ff};
      ge      = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[pgmo_pkg::DIV_W-1:0] : trial[pgmo_pkg::DIV_W-1:0];
         quo_in = {quo_ff[pgmo_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> rtl/core/pgmo_ctrl.sv
// Sequencer: pixel intake, buffer reads, arctangent series and result hand-off
module pgmo_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pgmo_pkg::sts_type sts,
   output pgmo_pkg::cmd_type cmd
);
   pgmo_pkg::state_type  state_ff, state_in;
   pgmo_pkg::job_type    job_ff, job_in;
   pgmo_pkg::div_op_type op_ff, op_in;
   logic                 scale2_ff, scale2_in;
   logic                 second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pgmo_pkg::ST_PI_A;
         job_ff    <= pgmo_pkg::JOB_PI5;
         op_ff     <= pgmo_pkg::DIV_TERM0;
         scale2_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         job_ff    <= job_in;
         op_ff     <= op_in;
         scale2_ff <= scale2_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      op_in     = op_ff;
      scale2_in = scale2_ff;
      second_in = second_ff;
      cmd       = '0;
      cmd.job   = job_ff;
      req_ready = 1'b0;
      case (state_ff)
         pgmo_pkg::ST_PI_A: begin
            cmd.arg  = pgmo_pkg::ARG_PI5;
            job_in   = pgmo_pkg::JOB_PI5;
            state_in = pgmo_pkg::ST_TERM0;
         end
         pgmo_pkg::ST_PI_B: begin
            cmd.arg  = pgmo_pkg::ARG_PI239;
            job_in   = pgmo_pkg::JOB_PI239;
            state_in = pgmo_pkg::ST_TERM0;
         end
         pgmo_pkg::ST_TERM0: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = pgmo_pkg::DIV_TERM0;
            op_in         = pgmo_pkg::DIV_TERM0;
            scale2_in     = 1'b0;
            state_in      = pgmo_pkg::ST_DIVW;
         end
         pgmo_pkg::ST_CHECK: begin
            if (sts.term_zero || sts.n_max) begin
               state_in = pgmo_pkg::ST_SER_END;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_op    = pgmo_pkg::DIV_ADD;
               op_in         = pgmo_pkg::DIV_ADD;
               state_in      = pgmo_pkg::ST_DIVW;
            end
         end
         pgmo_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = pgmo_pkg::ST_SCALE;
         end
         pgmo_pkg::ST_SCALE: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = pgmo_pkg::DIV_SCALE;
            op_in         = pgmo_pkg::DIV_SCALE;
            state_in      = pgmo_pkg::ST_DIVW;
         end
         pgmo_pkg::ST_DIVW: begin
            if (sts.div_done) begin
               case (op_ff)
                  pgmo_pkg::DIV_TERM0: state_in = pgmo_pkg::ST_CHECK;
                  pgmo_pkg::DIV_ADD:   state_in = pgmo_pkg::ST_MUL;
                  pgmo_pkg::DIV_SCALE: begin
                     if (scale2_ff) begin
                        scale2_in = 1'b0;
                        cmd.n_inc = 1'b1;
                        state_in  = pgmo_pkg::ST_CHECK;
                     end else begin
                        scale2_in = 1'b1;
                        state_in  = pgmo_pkg::ST_MUL;
                     end
                  end
                  pgmo_pkg::DIV_K:     state_in = pgmo_pkg::ST_EMIT;
                  default:             state_in = pgmo_pkg::ST_IDLE;
               endcase
            end
         end
         pgmo_pkg::ST_SER_END: begin
            cmd.ser_end = 1'b1;
            case (job_ff)
               pgmo_pkg::JOB_PI5:   state_in = pgmo_pkg::ST_PI_B;
               pgmo_pkg::JOB_PI239: state_in = pgmo_pkg::ST_IDLE;
               pgmo_pkg::JOB_OCT:   state_in = pgmo_pkg::ST_KDIV;
               default:             state_in = pgmo_pkg::ST_IDLE;
            endcase
         end
         pgmo_pkg::ST_KDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = pgmo_pkg::DIV_K;
            op_in         = pgmo_pkg::DIV_K;
            state_in      = pgmo_pkg::ST_DIVW;
         end
         pgmo_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = pgmo_pkg::ST_READ_A;
            end
         end
         pgmo_pkg::ST_READ_A: state_in = pgmo_pkg::ST_READ_B;
         pgmo_pkg::ST_READ_B: begin
            cmd.rd_b  = 1'b1;
            cmd.cap_a = 1'b1;
            state_in  = pgmo_pkg::ST_READ_C;
         end
         pgmo_pkg::ST_READ_C: begin
            cmd.cap_b = 1'b1;
            state_in  = pgmo_pkg::ST_DECIDE;
         end
         pgmo_pkg::ST_DECIDE: begin
            if (sts.has_first) begin
               cmd.setup = 1'b1;
               second_in = 1'b0;
               state_in  = pgmo_pkg::ST_RES_PREP;
            end else if (sts.has_second) begin
               cmd.setup  = 1'b1;
               cmd.second = 1'b1;
               second_in  = 1'b1;
               state_in   = pgmo_pkg::ST_RES_PREP;
            end else begin
               state_in = pgmo_pkg::ST_FINISH;
            end
         end
         pgmo_pkg::ST_RES_PREP: begin
            if (sts.special) begin
               state_in = pgmo_pkg::ST_EMIT;
            end else begin
               job_in   = pgmo_pkg::JOB_OCT;
               state_in = pgmo_pkg::ST_TERM0;
            end
         end
         pgmo_pkg::ST_EMIT: begin
            if (sts.sqrt_done && sts.out_free) begin
               cmd.load_out = 1'b1;
               if (!second_ff && sts.has_second) begin
                  cmd.setup  = 1'b1;
                  cmd.second = 1'b1;
                  second_in  = 1'b1;
                  state_in   = pgmo_pkg::ST_RES_PREP;
               end else begin
                  state_in = pgmo_pkg::ST_FINISH;
               end
            end
         end
         pgmo_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = pgmo_pkg::ST_IDLE;
         end
         default: state_in = pgmo_pkg::ST_IDLE;
      endcase
   end
endmodule

>>> rtl/core/pgmo_dp.sv
// Datapath: row buffers, gradients, square root, arctangent series, output word
module pgmo_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pgmo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pgmo_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [pgmo_pkg::PIX_W-1:0]        req_pixel,
   input  pgmo_pkg::cmd_type                 cmd,
   output pgmo_pkg::sts_type                 sts,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic [pgmo_pkg::MAG_W-1:0]        out_magnitude,
   output logic [pgmo_pkg::ORI_W-1:0]        out_orientation,
   output logic [pgmo_pkg::COL_W-1:0]        out_column,
   output logic [pgmo_pkg::ROW_W-1:0]        out_row,
   output logic                              out_last
);
   localparam int AW = $clog2(pgmo_pkg::MAX_WIDTH);

   // configuration and frame geometry
   logic [pgmo_pkg::CFG_W_W-1:0] cfg_w_ff, frame_w_ff, clamp_w, eff_w, eff_wm1, wm1;
   logic [pgmo_pkg::CFG_H_W-1:0] cfg_h_ff, frame_h_ff, clamp_h, eff_h;
   logic [pgmo_pkg::COL_W-1:0]   col_cnt_ff, cur_c_ff, acc_c, last_col, j_idx, left_idx;
   logic [pgmo_pkg::ROW_W-1:0]   row_cnt_ff, cur_r_ff, acc_r;
   logic [pgmo_pkg::ROW_W:0]     r_next;
   logic                         start_frame, at_end, has_first, has_second;
   logic [pgmo_pkg::PIX_W-1:0]   prev_ff, old_prev_ff, pix_ff;
   logic [1:0]                   fill_sel_ff, one_sel_ff, two_sel_ff;

   // buffer reads
   logic [AW-1:0]                one_addr, two_addr;
   logic [pgmo_pkg::PIX_W-1:0]   bank_rd [3];
   logic [pgmo_pkg::PIX_W-1:0]   one_data, two_data;
   logic [pgmo_pkg::PIX_W-1:0]   left_ff, above_ff, right_ff, end_above_ff;

   // result setup
   logic signed [pgmo_pkg::PIX_W:0] dx_s, dy_s;
   logic [pgmo_pkg::PIX_W-1:0]   u_abs, w_abs, a_v, b_v;
   logic [16:0]                  sq_sum;
   logic                         swap_v, br2_v, dyp, neg_v;
   logic                         dxz_ff, wz_ff, eq_ff, swap_ff, br2_ff, neg_ff;
   logic [pgmo_pkg::ARG_W-1:0]   p_ff, q_ff;
   logic [pgmo_pkg::COL_W-1:0]   res_col_ff;
   logic [pgmo_pkg::ROW_W-1:0]   res_row_ff;
   logic                         res_last_ff;

   // square root
   logic [pgmo_pkg::SQ_W-1:0]    sq_rem_ff, sq_q_ff, sq_bit_ff, sq_t;
   logic                         sq_busy_ff;

   // series
   pgmo_pkg::term_type           term_ff, quo_t;
   pgmo_pkg::prod_type           prod_ff;
   pgmo_pkg::ang_type            sum_ff, pacc_ff, pi_ff, theta_ff;
   logic [pgmo_pkg::N_W-1:0]     n_ff;
   logic [pgmo_pkg::K_W-1:0]     k_ff;
   pgmo_pkg::div_op_type         op_ff;
   pgmo_pkg::div_word_type       div_a, div_b, div_q;
   logic                         div_busy, div_done;

   // output
   pgmo_pkg::ori_type            oct_v, qc_v, ori_v;
   logic                         out_valid_ff;
   logic [pgmo_pkg::MAG_W-1:0]   out_mag_ff;
   pgmo_pkg::ori_type            out_ori_ff;
   logic [pgmo_pkg::COL_W-1:0]   out_col_ff;
   logic [pgmo_pkg::ROW_W-1:0]   out_row_ff;
   logic                         out_last_ff;

   // geometry
   always_comb begin
      start_frame = (col_cnt_ff == '0) && (row_cnt_ff == '0);
      if (cfg_w_ff < pgmo_pkg::WIDTH_MIN) begin
         clamp_w = pgmo_pkg::WIDTH_MIN;
      end else if (cfg_w_ff > pgmo_pkg::WIDTH_MAX) begin
         clamp_w = pgmo_pkg::WIDTH_MAX;
      end else begin
         clamp_w = cfg_w_ff;
      end
      clamp_h = (cfg_h_ff < pgmo_pkg::HEIGHT_MIN) ? pgmo_pkg::HEIGHT_MIN : cfg_h_ff;
      eff_w   = start_frame ? clamp_w : frame_w_ff;
      eff_h   = start_frame ? clamp_h : frame_h_ff;
      eff_wm1 = eff_w - 1'b1;
      acc_c   = ({1'b0, col_cnt_ff} >= eff_w) ? eff_wm1[pgmo_pkg::COL_W-1:0] : col_cnt_ff;
      acc_r   = (row_cnt_ff >= eff_h) ? eff_h - 1'b1 : row_cnt_ff;
      wm1        = frame_w_ff - 1'b1;
      last_col   = wm1[pgmo_pkg::COL_W-1:0];
      at_end     = ({1'b0, cur_c_ff} == wm1);
      has_first  = (cur_r_ff >= 12'd2) && (cur_c_ff != '0);
      has_second = (cur_r_ff >= 12'd2) && at_end;
      j_idx      = cur_c_ff - 1'b1;
      left_idx   = (j_idx == '0) ? 10'd1 : j_idx - 1'b1;
      one_addr   = cmd.rd_b ? cur_c_ff : left_idx;
      two_addr   = cmd.rd_b ? last_col : j_idx;
      r_next     = {1'b0, cur_r_ff} + 1'b1;
      one_data   = bank_rd[one_sel_ff];
      two_data   = bank_rd[two_sel_ff];
   end

   for (genvar b = 0; b < 3; b++) begin : g_bank
      pgmo_ram #(
         .WIDTH(pgmo_pkg::PIX_W),
         .DEPTH(pgmo_pkg::MAX_WIDTH)
      ) u_ram (
         .clock(clock),
         .we   (cmd.accept && (fill_sel_ff == 2'(b))),
         .waddr(acc_c),
         .wdata(req_pixel),
         .raddr((one_sel_ff == 2'(b)) ? one_addr : two_addr),
         .rdata(bank_rd[b])
      );
   end

   // gradient setup
   always_comb begin
      if (cmd.second) begin
         dx_s = '0;
         dy_s = $signed({1'b0, pix_ff}) - $signed({1'b0, end_above_ff});
      end else begin
         dx_s = $signed({1'b0, right_ff}) - $signed({1'b0, left_ff});
         dy_s = $signed({1'b0, old_prev_ff}) - $signed({1'b0, above_ff});
      end
      u_abs  = dx_s[pgmo_pkg::PIX_W] ? 8'(-dx_s) : dx_s[pgmo_pkg::PIX_W-1:0];
      w_abs  = dy_s[pgmo_pkg::PIX_W] ? 8'(-dy_s) : dy_s[pgmo_pkg::PIX_W-1:0];
      dyp    = !dy_s[pgmo_pkg::PIX_W] && (dy_s != '0);
      neg_v  = dx_s[pgmo_pkg::PIX_W] ? dyp : dy_s[pgmo_pkg::PIX_W];
      swap_v = u_abs > w_abs;
      a_v    = swap_v ? w_abs : u_abs;
      b_v    = swap_v ? u_abs : w_abs;
      br2_v  = {a_v, 1'b0} > {1'b0, b_v};
      sq_sum = 17'(u_abs) * 17'(u_abs) + 17'(w_abs) * 17'(w_abs);
   end

   // divider operands
   always_comb begin
      case (cmd.div_op)
         pgmo_pkg::DIV_TERM0: begin
            div_a = pgmo_pkg::div_word_type'({p_ff, {pgmo_pkg::FRAC{1'b0}}});
            div_b = pgmo_pkg::div_word_type'(q_ff);
         end
         pgmo_pkg::DIV_ADD: begin
            div_a = pgmo_pkg::div_word_type'(term_ff);
            div_b = pgmo_pkg::div_word_type'({n_ff, 1'b1});
         end
         pgmo_pkg::DIV_SCALE: begin
            div_a = pgmo_pkg::div_word_type'(prod_ff);
            div_b = pgmo_pkg::div_word_type'(q_ff);
         end
         pgmo_pkg::DIV_K: begin
            div_a = pgmo_pkg::div_word_type'({theta_ff, 16'h0000})
                  + pgmo_pkg::div_word_type'(pi_ff);
            div_b = pgmo_pkg::div_word_type'({pi_ff, 1'b0});
         end
         default: begin
            div_a = '0;
            div_b = '0;
         end
      endcase
   end

   pgmo_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(div_a),
      .divisor (div_b),
      .busy    (div_busy),
      .done    (div_done),
      .quotient(div_q)
   );

   // orientation assembly
   always_comb begin
      quo_t = div_q[pgmo_pkg::TERM_W-1:0];
      sq_t  = sq_q_ff + sq_bit_ff;
      oct_v = eq_ff ? pgmo_pkg::ORI_EIGHTH : pgmo_pkg::ori_type'(k_ff);
      if (wz_ff) begin
         qc_v = pgmo_pkg::ORI_QUARTER;
      end else if (swap_ff) begin
         qc_v = pgmo_pkg::ORI_QUARTER - oct_v;
      end else begin
         qc_v = oct_v;
      end
      if (dxz_ff) begin
         ori_v = neg_ff ? pgmo_pkg::ORI_HALF : '0;
      end else begin
         ori_v = neg_ff ? pgmo_pkg::ORI_HALF - qc_v : qc_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff     <= pgmo_pkg::WIDTH_RESET;
         cfg_h_ff     <= pgmo_pkg::HEIGHT_RESET;
         frame_w_ff   <= pgmo_pkg::WIDTH_RESET;
         frame_h_ff   <= pgmo_pkg::HEIGHT_RESET;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         prev_ff      <= '0;
         fill_sel_ff  <= 2'd0;
         one_sel_ff   <= 2'd1;
         two_sel_ff   <= 2'd2;
         sq_busy_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               pgmo_pkg::REG_IMAGE_WIDTH:  cfg_w_ff <= csr_wdata[pgmo_pkg::CFG_W_W-1:0];
               pgmo_pkg::REG_IMAGE_HEIGHT: cfg_h_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.accept) begin
            frame_w_ff <= eff_w;
            frame_h_ff <= eff_h;
            prev_ff    <= req_pixel;
         end
         if (cmd.finish) begin
            if (at_end) begin
               col_cnt_ff  <= '0;
               row_cnt_ff  <= (r_next >= {1'b0, frame_h_ff}) ? '0 : r_next[pgmo_pkg::ROW_W-1:0];
               two_sel_ff  <= one_sel_ff;
               one_sel_ff  <= fill_sel_ff;
               fill_sel_ff <= two_sel_ff;
            end else begin
               col_cnt_ff <= cur_c_ff + 1'b1;
               row_cnt_ff <= cur_r_ff;
            end
         end
         if (cmd.setup) begin
            sq_busy_ff <= 1'b1;
         end else if (sq_busy_ff && (sq_bit_ff == '0)) begin
            sq_busy_ff <= 1'b0;
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end

      if (cmd.accept) begin
         cur_c_ff    <= acc_c;
         cur_r_ff    <= acc_r;
         pix_ff      <= req_pixel;
         old_prev_ff <= prev_ff;
      end
      if (cmd.cap_a) begin
         left_ff  <= one_data;
         above_ff <= two_data;
      end
      if (cmd.cap_b) begin
         right_ff     <= one_data;
         end_above_ff <= two_data;
      end

      case (cmd.arg)
         pgmo_pkg::ARG_PI5: begin
            p_ff <= pgmo_pkg::PI_P;
            q_ff <= pgmo_pkg::PI_Q_A;
         end
         pgmo_pkg::ARG_PI239: begin
            p_ff <= pgmo_pkg::PI_P;
            q_ff <= pgmo_pkg::PI_Q_B;
         end
         default: ;
      endcase

      if (cmd.setup) begin
         dxz_ff      <= (dx_s == '0);
         wz_ff       <= (w_abs == '0);
         eq_ff       <= (a_v == b_v);
         swap_ff     <= swap_v;
         br2_ff      <= br2_v;
         neg_ff      <= neg_v;
         p_ff        <= br2_v ? 10'(b_v) - 10'(a_v) : 10'(a_v);
         q_ff        <= br2_v ? 10'(b_v) + 10'(a_v) : 10'(b_v);
         res_col_ff  <= cmd.second ? last_col : j_idx;
         res_row_ff  <= cur_r_ff - 1'b1;
         res_last_ff <= cmd.second || !has_second;
         sq_rem_ff   <= {1'b0, sq_sum, 8'h00};
         sq_q_ff     <= '0;
         sq_bit_ff   <= pgmo_pkg::SQ_W'(1) << 24;
      end else if (sq_busy_ff) begin
         if (sq_bit_ff != '0) begin
            if (sq_rem_ff >= sq_t) begin
               sq_rem_ff <= sq_rem_ff - sq_t;
               sq_q_ff   <= (sq_q_ff >> 1) + sq_bit_ff;
            end else begin
               sq_q_ff <= sq_q_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end else if (sq_rem_ff > sq_q_ff) begin
            sq_q_ff <= sq_q_ff + 1'b1;
         end
      end

      if (cmd.div_start) begin
         op_ff <= cmd.div_op;
      end
      if (div_done) begin
         case (op_ff)
            pgmo_pkg::DIV_TERM0: begin
               term_ff <= quo_t;
               sum_ff  <= '0;
               n_ff    <= '0;
            end
            pgmo_pkg::DIV_ADD: begin
               sum_ff <= n_ff[0] ? sum_ff - pgmo_pkg::ang_type'(quo_t)
                                 : sum_ff + pgmo_pkg::ang_type'(quo_t);
            end
            pgmo_pkg::DIV_SCALE: term_ff <= quo_t;
            pgmo_pkg::DIV_K:     k_ff    <= div_q[pgmo_pkg::K_W-1:0];
            default: ;
         endcase
      end
      if (cmd.mul) begin
         prod_ff <= pgmo_pkg::prod_type'(term_ff) * pgmo_pkg::prod_type'(p_ff);
      end
      if (cmd.n_inc) begin
         n_ff <= n_ff + 1'b1;
      end
      if (cmd.ser_end) begin
         case (cmd.job)
            pgmo_pkg::JOB_PI5:   pacc_ff  <= sum_ff << 4;
            pgmo_pkg::JOB_PI239: pi_ff    <= pacc_ff - (sum_ff << 2);
            pgmo_pkg::JOB_OCT:   theta_ff <= br2_ff ? (pi_ff >> 2) - sum_ff : sum_ff;
            default: ;
         endcase
      end

      if (cmd.load_out) begin
         out_mag_ff  <= sq_q_ff[pgmo_pkg::MAG_W-1:0];
         out_ori_ff  <= ori_v;
         out_col_ff  <= res_col_ff;
         out_row_ff  <= res_row_ff;
         out_last_ff <= res_last_ff;
      end
   end

   always_comb begin
      sts.has_first  = has_first;
      sts.has_second = has_second;
      sts.special    = dxz_ff || wz_ff || eq_ff;
      sts.term_zero  = (term_ff == '0);
      sts.n_max      = (n_ff == pgmo_pkg::N_MAX);
      sts.div_done   = div_done;
      sts.div_busy   = div_busy;
      sts.sqrt_done  = !sq_busy_ff;
      sts.out_free   = !out_valid_ff || out_ready;
   end

   assign out_valid       = out_valid_ff;
   assign out_magnitude   = out_mag_ff;
   assign out_orientation = out_ori_ff;
   assign out_column      = out_col_ff;
   assign out_row         = out_row_ff;
   assign out_last        = out_last_ff;
endmodule

>>> rtl/core/pixel_gradient_magnitude_orientation_core.sv
// Gradient magnitude and unsigned orientation core, top level.
// Takes one grey pixel per word in raster order and returns, for each interior
// row, the central-difference gradient of the row above: magnitude in U9.4 and
// orientation in units of pi/32768, with column and row of the centre pixel.
// The last pixel of a row gives two words. One pixel is handled at a time: a
// pixel with no result only goes through the buffer reads; a result with a
// trivial angle (axis or diagonal) waits for the 13-step square root;
// otherwise the arctangent series runs on a single shared restoring divider,
// three divides per term, for 2 to 22 terms. After reset the core first derives
// pi the same way and accepts no pixel until it is done; register writes are
// taken throughout. A finished word waits in the output register while the next
// pixel is accepted. Frame sizes are latched at the first pixel of each frame.
module pixel_gradient_magnitude_orientation_core (
   input  logic                             clock,
   input  logic                             reset,
   pgmo_req_if.sink                         req,
   pgmo_rsp_if.source                       rsp,
   input  logic                             csr_we,
   input  logic [pgmo_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pgmo_pkg::CSR_DATA_W-1:0]  csr_wdata
);
`include "pixel_gradient_magnitude_orientation_core_assert.svh"

   pgmo_pkg::cmd_type cmd;
   pgmo_pkg::sts_type sts;
   logic              ready;

   pgmo_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req.valid),
      .req_ready(ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   pgmo_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_pixel      (req.pixel),
      .cmd            (cmd),
      .sts            (sts),
      .out_ready      (rsp.ready),
      .out_valid      (rsp.valid),
      .out_magnitude  (rsp.magnitude),
      .out_orientation(rsp.orientation),
      .out_column     (rsp.column),
      .out_row        (rsp.row),
      .out_last       (rsp.last_in_run)
   );

   assign req.ready = ready;

   `PGMO_ASSERT_NEXT(a_one_pixel_at_a_time, clock, reset, req.valid && req.ready, !req.ready, "pixel accepted while previous still in work")
   `PGMO_ASSERT_NOW(a_div_not_restarted, clock, reset, sts.div_busy, !cmd.div_start, "divider restarted while busy")
   `PGMO_ASSERT_NOW(a_load_when_free, clock, reset, cmd.load_out, !rsp.valid || rsp.ready, "output word overwritten")
endmodule

>>> tb/tb_pixel_gradient_magnitude_orientation_core.sv
// Self-checking bench for the gradient core: frames of pixels in, checked gradient words out
module tb_pixel_gradient_magnitude_orientation_core;

   typedef logic [63:0] u64_type;

   typedef struct packed {
      logic [pgmo_pkg::MAG_W-1:0] magnitude;
      logic [pgmo_pkg::ORI_W-1:0] orientation;
      logic [pgmo_pkg::COL_W-1:0] column;
      logic [pgmo_pkg::ROW_W-1:0] row;
      logic                       last_in_run;
   } grad_word_type;

   logic clock;
   logic reset;
   logic                            csr_we;
   logic [pgmo_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pgmo_pkg::CSR_DATA_W-1:0] csr_wdata;

   pgmo_req_if req_ch();
   pgmo_rsp_if rsp_ch();

   pixel_gradient_magnitude_orientation_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [pgmo_pkg::PIX_W-1:0] pixel_queue[$];
   grad_word_type              grad_expected[$];
   int                         errors;
   int                         words_checked;
   int                         pixels_sent;
   int                         frames_run;
   bit                         idle_on;
   int                         send_gap;
   int                         recv_stall;

   // shadow of the core state
   logic [pgmo_pkg::CFG_W_W-1:0] shadow_width;
   logic [pgmo_pkg::CFG_H_W-1:0] shadow_height;
   int                           frame_w;
   int                           frame_h;
   logic [pgmo_pkg::PIX_W-1:0]   row_back1[pgmo_pkg::MAX_WIDTH];
   logic [pgmo_pkg::PIX_W-1:0]   row_back2[pgmo_pkg::MAX_WIDTH];
   logic [pgmo_pkg::PIX_W-1:0]   row_fill[pgmo_pkg::MAX_WIDTH];
   logic [pgmo_pkg::PIX_W-1:0]   last_pixel;
   int                           col_count;
   int                           row_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #1000000000;
      $display("tb: failure");
      $finish;
   end

   // arctangent of p/q, 44 fraction bits, Taylor series with truncation
   function automatic u64_type atan_fx(input u64_type p, input u64_type q);
      u64_type sum;
      u64_type term;
      u64_type n;
      sum = 0;
      term = (p << pgmo_pkg::FRAC) / q;
      n = 0;
      while (term != 0 && n < 200) begin
         if (n[0] == 1'b0) sum = sum + term / (2 * n + 1);
         else sum = sum - term / (2 * n + 1);
         term = term * p / q;
         term = term * p / q;
         n++;
      end
      return sum;
   endfunction

   function automatic u64_type pi_fx();
      return 16 * atan_fx(1, 5) - 4 * atan_fx(1, 239);
   endfunction

   function automatic int octant_angle(input int a, input int b);
      u64_type pi;
      u64_type theta;
      if (a == b) return int'(pgmo_pkg::ORI_EIGHTH);
      pi = pi_fx();
      if (2 * a <= b) theta = atan_fx(a, b);
      else theta = pi / 4 - atan_fx(b - a, b + a);
      return int'((theta * 65536 + pi) / (2 * pi));
   endfunction

   function automatic int quadrant_angle(input int u, input int w);
      if (w == 0) return int'(pgmo_pkg::ORI_QUARTER);
      if (u <= w) return octant_angle(u, w);
      return int'(pgmo_pkg::ORI_QUARTER) - octant_angle(w, u);
   endfunction

   function automatic int grad_angle(input int dx, input int dy);
      if (dx == 0) return (dy < 0) ? int'(pgmo_pkg::ORI_HALF) : 0;
      if (dx < 0) begin
         dx = -dx;
         dy = -dy;
      end
      if (dy >= 0) return quadrant_angle(dx, dy);
      return int'(pgmo_pkg::ORI_HALF) - quadrant_angle(dx, -dy);
   endfunction

   function automatic int grad_magnitude(input int dx, input int dy);
      u64_type s;
      u64_type q;
      u64_type bitv;
      u64_type rem;
      s = u64_type'(dx * dx + dy * dy) * 256;
      q = 0;
      bitv = u64_type'(1) << 40;
      rem = s;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= q + bitv) begin
            rem = rem - (q + bitv);
            q = (q >> 1) + bitv;
         end else begin
            q = q >> 1;
         end
         bitv = bitv >> 2;
      end
      if (rem > q) q++;
      return int'(q);
   endfunction

   function automatic grad_word_type make_word(input int dx, input int dy, input int c,
                                               input int r);
      grad_word_type g;
      g.magnitude   = pgmo_pkg::MAG_W'(grad_magnitude(dx, dy));
      g.orientation = pgmo_pkg::ORI_W'(grad_angle(dx, dy));
      g.column      = pgmo_pkg::COL_W'(c);
      g.row         = pgmo_pkg::ROW_W'(r);
      g.last_in_run = 1'b0;
      return g;
   endfunction

   task automatic predict_pixel(input logic [pgmo_pkg::PIX_W-1:0] pix);
      int c;
      int r;
      int j;
      int left;
      int n;
      grad_word_type g;
      if (col_count == 0 && row_count == 0) begin
         frame_w = shadow_width;
         if (frame_w < 3) frame_w = 3;
         if (frame_w > pgmo_pkg::MAX_WIDTH) frame_w = pgmo_pkg::MAX_WIDTH;
         frame_h = shadow_height;
         if (frame_h < 3) frame_h = 3;
      end
      c = (col_count >= frame_w) ? frame_w - 1 : col_count;
      r = (row_count >= frame_h) ? frame_h - 1 : row_count;
      row_fill[c] = pix;
      n = 0;
      if (r >= 2 && c >= 1) begin
         j = c - 1;
         left = (j == 0) ? row_back1[1] : row_back1[j - 1];
         g = make_word(int'(row_back1[c]) - left, int'(last_pixel) - int'(row_back2[j]),
                       j, r - 1);
         g.last_in_run = (c != frame_w - 1);
         grad_expected.insert(grad_expected.size(), g);
         n++;
      end
      if (r >= 2 && c == frame_w - 1) begin
         g = make_word(0, int'(pix) - int'(row_back2[frame_w - 1]), frame_w - 1, r - 1);
         g.last_in_run = 1'b1;
         grad_expected.insert(grad_expected.size(), g);
      end
      last_pixel = pix;
      if (c == frame_w - 1) begin
         row_back2 = row_back1;
         row_back1 = row_fill;
         col_count = 0;
         row_count = (r + 1 >= frame_h) ? 0 : r + 1;
      end else begin
         col_count = c + 1;
         row_count = r;
      end
   endtask

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_pixel(req_ch.pixel);
            pixels_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               req_ch.valid <= 1'b1;
               req_ch.pixel <= pixel_queue.pop_front();
               if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 11);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // gradient word monitor
   always @(posedge clock) begin
      grad_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (grad_expected.size() == 0) begin
               $display("%0t: unexpected word mag=%0d ori=%0d col=%0d row=%0d last=%0d",
                        $time, rsp_ch.magnitude, rsp_ch.orientation, rsp_ch.column,
                        rsp_ch.row, rsp_ch.last_in_run);
               errors++;
            end else begin
               want = grad_expected.pop_front();
               words_checked++;
               if (rsp_ch.magnitude !== want.magnitude) begin
                  $display("%0t: magnitude exp %0d got %0d", $time, want.magnitude,
                           rsp_ch.magnitude);
                  errors++;
               end
               if (rsp_ch.orientation !== want.orientation) begin
                  $display("%0t: orientation exp %0d got %0d", $time, want.orientation,
                           rsp_ch.orientation);
                  errors++;
               end
               if (rsp_ch.column !== want.column) begin
                  $display("%0t: column exp %0d got %0d", $time, want.column, rsp_ch.column);
                  errors++;
               end
               if (rsp_ch.row !== want.row) begin
                  $display("%0t: row exp %0d got %0d", $time, want.row, rsp_ch.row);
                  errors++;
               end
               if (rsp_ch.last_in_run !== want.last_in_run) begin
                  $display("%0t: last_in_run exp %0d got %0d", $time, want.last_in_run,
                           rsp_ch.last_in_run);
                  errors++;
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 11) == 0) recv_stall = $urandom_range(1, 11);
         end
      end
   end

   task automatic write_reg(input logic [pgmo_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pgmo_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == pgmo_pkg::REG_IMAGE_WIDTH) shadow_width = val[pgmo_pkg::CFG_W_W-1:0];
      else shadow_height = val[pgmo_pkg::CFG_H_W-1:0];
   endtask

   // mode 0 uniform, 1 constant per row, 2 black or white, 3 small steps around a level
   task automatic run_frame(input int wreg, input int hreg, input int mode);
      int w;
      int h;
      int level;
      logic [pgmo_pkg::PIX_W-1:0] p;
      write_reg(pgmo_pkg::REG_IMAGE_WIDTH, pgmo_pkg::CSR_DATA_W'(wreg));
      write_reg(pgmo_pkg::REG_IMAGE_HEIGHT, pgmo_pkg::CSR_DATA_W'(hreg));
      w = wreg & 12'h7FF;
      if (w < 3) w = 3;
      if (w > pgmo_pkg::MAX_WIDTH) w = pgmo_pkg::MAX_WIDTH;
      h = (hreg < 3) ? 3 : hreg;
      level = $urandom_range(4, 251);
      for (int r = 0; r < h; r++) begin
         if (mode == 1) p = pgmo_pkg::PIX_W'($urandom);
         for (int c = 0; c < w; c++) begin
            case (mode)
               0: p = pgmo_pkg::PIX_W'($urandom);
               2: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               3: p = pgmo_pkg::PIX_W'(level + $urandom_range(0, 8) - 4);
               default: ;
            endcase
            pixel_queue.insert(pixel_queue.size(), p);
         end
      end
      frames_run++;
      while (pixel_queue.size() != 0 || req_ch.valid || grad_expected.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      int wreg;
      int hreg;
      errors = 0;
      words_checked = 0;
      pixels_sent = 0;
      frames_run = 0;
      idle_on = 1'b1;
      shadow_width = pgmo_pkg::WIDTH_RESET;
      shadow_height = pgmo_pkg::HEIGHT_RESET;
      frame_w = pgmo_pkg::MAX_WIDTH;
      frame_h = 4095;
      last_pixel = '0;
      col_count = 0;
      row_count = 0;
      for (int i = 0; i < pgmo_pkg::MAX_WIDTH; i++) begin
         row_back1[i] = '0;
         row_back2[i] = '0;
         row_fill[i] = '0;
      end
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: smallest frames, clamped sizes, black/white extremes
      run_frame(3, 3, 0);
      run_frame(0, 0, 2);
      run_frame(2, 1, 2);
      run_frame(4, 2, 3);

      while (pixels_sent < 1700) begin
         if (pixels_sent > 1400) idle_on = 1'b0;
         else idle_on = ($urandom_range(0, 3) != 0);
         wreg = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 8);
         hreg = $urandom_range(3, 6);
         run_frame(wreg, hreg, $urandom_range(0, 3));
      end

      $display("covered %0d frames, %0d pixels, %0d gradient words checked",
               frames_run, pixels_sent, words_checked);
      $display("sizes from the clamped minimum up to 40 wide and 6 tall, with random stalls");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> pixel_gradient_magnitude_orientation_core.f
+incdir+rtl/core
rtl/core/pgmo_pkg.sv
rtl/core/pgmo_if.sv
rtl/core/pgmo_ram.sv
rtl/core/pgmo_div.sv
rtl/core/pgmo_ctrl.sv
rtl/core/pgmo_dp.sv
rtl/core/pixel_gradient_magnitude_orientation_core.sv
tb/tb_pixel_gradient_magnitude_orientation_core.sv
